>>> design/cfq_pkg.sv
// shared types and request codes of the circular fifo queue
package cfq_pkg;

   // request kinds
   localparam logic [2:0] REQ_ENQ      = 3'd0;
   localparam logic [2:0] REQ_DEQ      = 3'd1;
   localparam logic [2:0] REQ_PEEK_OLD = 3'd2;
   localparam logic [2:0] REQ_PEEK_NEW = 3'd3;
   localparam logic [2:0] REQ_CLR      = 3'd4;

   // width of the reported count and of the item fields
   localparam int unsigned COUNT_OUT_W = 7;
   localparam int unsigned DATA_W      = 32;

   typedef struct packed {
      logic [2:0]        req_type;
      logic [DATA_W-1:0] item_value;
   } cfq_req_type;

   typedef struct packed {
      logic [DATA_W-1:0]      data_out;
      logic                   op_ok;
      logic [COUNT_OUT_W-1:0] item_count;
      logic                   empty_flag;
      logic                   full_flag;
      logic                   error_flag;
   } cfq_rsp_type;

   // outcome of one transaction, short of the data read from the store
   typedef struct packed {
      logic                   rd_used;
      logic                   op_ok;
      logic [COUNT_OUT_W-1:0] item_count;
      logic                   empty_flag;
      logic                   full_flag;
      logic                   error_flag;
   } cfq_stat_type;

endpackage

>>> design/cfq_ram.sv
// generic single write port, single read port ram with registered read
module cfq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, output holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/cfq_ctrl.sv
// queue pointers, count and error flag; decodes each request into store accesses
module cfq_ctrl #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [2:0]               req_kind,
   output logic                     wr_en,
   output logic [$clog2(DEPTH)-1:0] wr_addr,
   output logic                     rd_en,
   output logic [$clog2(DEPTH)-1:0] rd_addr,
   output cfq_pkg::cfq_stat_type    stat
);
   import cfq_pkg::*;

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
   localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);

   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             error_ff, error_in;
   logic             ok;
   logic             rd_used;
   logic [31:0]      count_wide;

   // next state and store accesses for the offered request
   always_comb begin
      rd_idx_in = rd_idx_ff;
      wr_idx_in = wr_idx_ff;
      count_in  = count_ff;
      error_in  = error_ff;
      ok        = 1'b0;
      rd_used   = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = wr_idx_ff;
      rd_addr   = rd_idx_ff;
      unique case (req_kind) inside
         REQ_ENQ: begin
            if (count_ff != CNT_FULL) begin
               wr_en     = accept;
               wr_idx_in = (wr_idx_ff == IDX_LAST) ? '0 : wr_idx_ff + IDX_ONE;
               count_in  = count_ff + CNT_ONE;
               ok        = 1'b1;
            end
         end
         REQ_DEQ, REQ_PEEK_OLD, REQ_PEEK_NEW: begin
            if (count_ff == '0) begin
               error_in = 1'b1;
            end else begin
               ok      = 1'b1;
               rd_used = 1'b1;
               rd_en   = accept;
               if (req_kind == REQ_PEEK_NEW) begin
                  // newest entry sits just below the write position
                  rd_addr = (wr_idx_ff == '0) ? IDX_LAST : wr_idx_ff - IDX_ONE;
               end
               if (req_kind == REQ_DEQ) begin
                  rd_idx_in = (rd_idx_ff == IDX_LAST) ? '0 : rd_idx_ff + IDX_ONE;
                  count_in  = count_ff - CNT_ONE;
               end
            end
         end
         REQ_CLR: begin
            wr_idx_in = rd_idx_ff;
            count_in  = '0;
            ok        = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // status as seen after this transaction
   assign count_wide      = 32'(count_in);
   assign stat.rd_used    = rd_used;
   assign stat.op_ok      = ok;
   assign stat.item_count = count_wide[COUNT_OUT_W-1:0];
   assign stat.empty_flag = (count_in == '0);
   assign stat.full_flag  = (count_in == CNT_FULL);
   assign stat.error_flag = error_in;

   // pointer and flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
         wr_idx_ff <= '0;
         count_ff  <= '0;
         error_ff  <= 1'b0;
      end else if (accept) begin
         rd_idx_ff <= rd_idx_in;
         wr_idx_ff <= wr_idx_in;
         count_ff  <= count_in;
         error_ff  <= error_in;
      end
   end

endmodule

>>> design/circular_fifo_queue_core.sv
// Circular FIFO queue core. Requests arrive on the req_ channel (valid/ready), each an
// enqueue, dequeue, peek at the oldest item, peek at the newest item or clear. Every
// request gives exactly one result on the rsp_ channel carrying the data read, a success
// bit, the item count, empty and full flags and a sticky error flag that a read of an
// empty queue sets; only reset clears it.
// A result passes through the registered read of the item store and then through the
// output register before it is shown on the rsp_ channel.
// Throughput: one request per cycle while the receiver takes results; the single read
// port of the item store and the one-entry read stage set that figure.
// When the receiver stalls, the output register holds its result and the read stage
// holds the next one (the store's read register keeps its data); req_ready then drops
// until the output register frees.
// Reset (synchronous, active high) empties the queue and clears the error flag at once;
// the item store itself is not cleared, which no request can observe.
module circular_fifo_queue_core #(
   parameter int unsigned DEPTH      = 64,
   parameter int unsigned ITEM_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cfq_pkg::cfq_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cfq_pkg::cfq_rsp_type rsp_data
);
   import cfq_pkg::*;

   localparam int unsigned IDX_W = $clog2(DEPTH);

   logic                  req_accept;
   logic                  load_out;
   logic                  wr_en;
   logic                  rd_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [IDX_W-1:0]      rd_addr;
   logic [ITEM_WIDTH-1:0] wr_data;
   logic [ITEM_WIDTH-1:0] rd_data;
   logic [63:0]           rd_wide;
   cfq_stat_type          stat;

   logic                  pend_ff, pend_in;
   cfq_stat_type          pend_stat_ff;
   logic                  out_valid_ff, out_valid_in;
   cfq_rsp_type           out_data_ff, out_data_in;

   // handshakes: the read stage moves on when the output register is free or being taken
   assign load_out   = pend_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !pend_ff || load_out;
   assign req_accept = req_valid && req_ready;

   cfq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .req_kind (req_data.req_type),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .stat     (stat)
   );

   // items are cut or zero-extended to the stored width
   assign wr_data = ITEM_WIDTH'({32'd0, req_data.item_value});

   cfq_ram #(
      .WIDTH (ITEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_wide = 64'(rd_data);

   // read stage: one transaction waiting for store data
   assign pend_in = req_accept || (pend_ff && !load_out);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pend_stat_ff <= stat;
      end
   end

   // output register
   always_comb begin
      out_data_in.data_out   = pend_stat_ff.rd_used ? rd_wide[DATA_W-1:0] : '0;
      out_data_in.op_ok      = pend_stat_ff.op_ok;
      out_data_in.item_count = pend_stat_ff.item_count;
      out_data_in.empty_flag = pend_stat_ff.empty_flag;
      out_data_in.full_flag  = pend_stat_ff.full_flag;
      out_data_in.error_flag = pend_stat_ff.error_flag;
   end

   assign out_valid_in = load_out || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTH
   // a stalled read stage must block new transactions
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && !load_out) |-> !req_accept)
      else $error("transaction accepted while read stage stalled");

   // every accepted transaction occupies the read stage next cycle
   a_accept_pends: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> pend_ff)
      else $error("accepted transaction lost before read stage");

   // a failed transaction never reports data
   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.op_ok) |-> (rsp_data.data_out == '0))
      else $error("failed transaction returned data");

   // full and empty never show together
   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.full_flag && rsp_data.empty_flag))
      else $error("full and empty flags both set");
`endif

endmodule

>>> test/tb_circular_fifo_queue_core.sv
// testbench for the circular fifo queue core: random and directed requests, scoreboard check
`timescale 1ns / 1ps

module tb_circular_fifo_queue_core;
   import cfq_pkg::*;

   localparam int unsigned QUEUE_DEPTH = 64;
   localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int unsigned LONG_HOLD   = 300;
   localparam int unsigned STALL_LIMIT = 3000;
   localparam int unsigned TAIL_CYCLES = 6;
   localparam int unsigned PRINT_CAP   = 100;
   localparam int unsigned RANDOM_REQS = 750;

   // request kinds the block ignores
   localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
   localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

   typedef struct {
      cfq_req_type req;
      int unsigned gap;
      bit          wait_drain;
      bit          hold_rx;
   } req_slot_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   cfq_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   cfq_rsp_type rsp_data;

   // stimulus backlog and expected results
   req_slot_type req_backlog[$];
   cfq_rsp_type  outcome_q[$];
   int unsigned sent_count = 0;
   int unsigned recv_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned quiet_cycles = 0;

   // mirror of the queue state
   logic [DATA_W-1:0] slots [QUEUE_DEPTH];
   logic [PTR_W-1:0]  rd_pos = '0;
   logic [PTR_W-1:0]  wr_pos = '0;
   int unsigned       fill_level = 0;
   logic              sticky_err = 1'b0;

   // driver and monitor bookkeeping
   int unsigned gap_left = 0;
   bit          hold_armed = 1'b0;
   logic        rx_hold_kick = 1'b0;
   int unsigned hold_left = 0;
   int unsigned stall_left = 0;
   int unsigned phase_left = 0;
   bit          calm_phase = 1'b0;

   circular_fifo_queue_core #(
      .DEPTH      (QUEUE_DEPTH),
      .ITEM_WIDTH (DATA_W)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // gap length: mostly none or short, now and then long
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // works out the result of one request and advances the mirrored state
   function automatic cfq_rsp_type queue_outcome(cfq_req_type rq);
      cfq_rsp_type o;
      o = '0;
      case (rq.req_type)
         REQ_ENQ: begin
            if (fill_level < QUEUE_DEPTH) begin
               slots[wr_pos] = rq.item_value;
               wr_pos = wr_pos + 1'b1;
               fill_level++;
               o.op_ok = 1'b1;
            end
         end
         REQ_DEQ, REQ_PEEK_OLD, REQ_PEEK_NEW: begin
            if (fill_level == 0) begin
               sticky_err = 1'b1;
            end else if (rq.req_type == REQ_PEEK_NEW) begin
               // pointer arithmetic wraps to the top entry when wr_pos is zero
               o.data_out = slots[wr_pos - 1'b1];
               o.op_ok = 1'b1;
            end else begin
               o.data_out = slots[rd_pos];
               o.op_ok = 1'b1;
               if (rq.req_type == REQ_DEQ) begin
                  rd_pos = rd_pos + 1'b1;
                  fill_level--;
               end
            end
         end
         REQ_CLR: begin
            wr_pos = rd_pos;
            fill_level = 0;
            o.op_ok = 1'b1;
         end
         default: ;
      endcase
      o.item_count = fill_level[COUNT_OUT_W-1:0];
      o.empty_flag = (fill_level == 0);
      o.full_flag  = (fill_level == QUEUE_DEPTH);
      o.error_flag = sticky_err;
      return o;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("mismatch at %0t ns: %s", $time, what);
   endtask

   task automatic check_result(input cfq_rsp_type got, input cfq_rsp_type want);
      if (got.data_out !== want.data_out)
         report_mismatch($sformatf("result %0d data_out %h, expected %h",
                                   recv_count, got.data_out, want.data_out));
      if (got.op_ok !== want.op_ok)
         report_mismatch($sformatf("result %0d op_ok %b, expected %b",
                                   recv_count, got.op_ok, want.op_ok));
      if (got.item_count !== want.item_count)
         report_mismatch($sformatf("result %0d item_count %0d, expected %0d",
                                   recv_count, got.item_count, want.item_count));
      if (got.empty_flag !== want.empty_flag)
         report_mismatch($sformatf("result %0d empty_flag %b, expected %b",
                                   recv_count, got.empty_flag, want.empty_flag));
      if (got.full_flag !== want.full_flag)
         report_mismatch($sformatf("result %0d full_flag %b, expected %b",
                                   recv_count, got.full_flag, want.full_flag));
      if (got.error_flag !== want.error_flag)
         report_mismatch($sformatf("result %0d error_flag %b, expected %b",
                                   recv_count, got.error_flag, want.error_flag));
   endtask

   task automatic add_req(input logic [2:0] kind, input logic [DATA_W-1:0] value,
                          input int unsigned gap, input bit drain, input bit hold);
      req_slot_type s;
      s.req.req_type   = kind;
      s.req.item_value = value;
      s.gap            = gap;
      s.wait_drain     = drain;
      s.hold_rx        = hold;
      req_backlog.push_back(s);
   endtask

   // stimulus, reset and end of run
   initial begin
      int unsigned budget;
      int unsigned run_len;
      int unsigned run_kind;
      int unsigned r;
      logic [2:0]  kind;
      logic [DATA_W-1:0] value;
      bit          quiet_run;
      bit          drain_next;

      // reads of an empty queue, spare kinds, extreme items, clear
      add_req(REQ_DEQ, $urandom, idle_len(), 1'b0, 1'b0);
      add_req(REQ_PEEK_OLD, $urandom, idle_len(), 1'b0, 1'b0);
      add_req(REQ_PEEK_NEW, $urandom, idle_len(), 1'b0, 1'b0);
      for (int k = REQ_SPARE_FIRST; k <= REQ_SPARE_LAST; k++)
         add_req(k[2:0], $urandom, idle_len(), 1'b0, 1'b0);
      add_req(REQ_ENQ, 32'h0000_0000, idle_len(), 1'b0, 1'b0);
      add_req(REQ_ENQ, 32'hFFFF_FFFF, idle_len(), 1'b0, 1'b0);
      add_req(REQ_PEEK_OLD, '0, idle_len(), 1'b0, 1'b0);
      add_req(REQ_PEEK_NEW, '0, idle_len(), 1'b0, 1'b0);
      add_req(REQ_ENQ, 32'hAAAA_AAAA, idle_len(), 1'b0, 1'b0);
      add_req(REQ_ENQ, 32'h5555_5555, idle_len(), 1'b0, 1'b0);
      add_req(REQ_PEEK_NEW, '0, idle_len(), 1'b0, 1'b0);
      for (int k = 0; k < 5; k++)
         add_req(REQ_DEQ, '0, idle_len(), 1'b0, 1'b0);
      add_req(REQ_CLR, '0, idle_len(), 1'b0, 1'b0);
      add_req(REQ_ENQ, 32'h0000_0001, idle_len(), 1'b0, 1'b0);
      add_req(REQ_ENQ, 32'h8000_0000, idle_len(), 1'b0, 1'b0);
      add_req(REQ_CLR, $urandom, idle_len(), 1'b0, 1'b0);
      add_req(REQ_PEEK_OLD, '0, idle_len(), 1'b0, 1'b0);

      // receiver holds off from the first of a burst of enqueues that overfills the queue
      add_req(REQ_ENQ, $urandom, 0, 1'b0, 1'b1);
      for (int k = 0; k < 69; k++)
         add_req(REQ_ENQ, $urandom, 0, 1'b0, 1'b0);
      // sender waits for every result before going on
      add_req(REQ_PEEK_NEW, '0, idle_len(), 1'b1, 1'b0);
      add_req(REQ_PEEK_OLD, '0, idle_len(), 1'b0, 1'b0);

      // random runs, each leaning towards filling, draining or a mix
      budget = RANDOM_REQS;
      drain_next = 1'b0;
      while (budget > 0) begin
         run_len = $urandom_range(10, 60);
         run_kind = $urandom_range(0, 2);
         quiet_run = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < run_len && budget > 0; k++) begin
            r = $urandom_range(0, 99);
            case (run_kind)
               0: kind = (r < 80) ? REQ_ENQ : (r < 90) ? REQ_DEQ :
                         (r < 95) ? REQ_PEEK_OLD : REQ_PEEK_NEW;
               1: kind = (r < 25) ? REQ_ENQ : (r < 75) ? REQ_DEQ :
                         (r < 87) ? REQ_PEEK_OLD : REQ_PEEK_NEW;
               default: kind = (r < 40) ? REQ_ENQ : (r < 68) ? REQ_DEQ :
                               (r < 79) ? REQ_PEEK_OLD : (r < 90) ? REQ_PEEK_NEW :
                               (r < 95) ? REQ_CLR :
                               3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST));
            endcase
            r = $urandom_range(0, 19);
            value = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
            add_req(kind, value, quiet_run ? 0 : idle_len(), drain_next, 1'b0);
            drain_next = 1'b0;
            if (kind <= REQ_CLR)
               budget--;
         end
         drain_next = ($urandom_range(0, 7) == 0);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_valid || sent_count != recv_count)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (outcome_q.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived", outcome_q.size()));
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // driver: offers backlog items, keeps valid and payload until taken
   always @(posedge clock) begin
      req_slot_type nxt;
      logic         taken;
      logic         kick;
      if (reset) begin
         req_valid <= 1'b0;
         rx_hold_kick <= 1'b0;
         gap_left = 0;
      end else begin
         taken = req_valid && req_ready;
         kick = 1'b0;
         if (taken) begin
            outcome_q.push_back(queue_outcome(req_data));
            sent_count <= sent_count + 1;
            kick = hold_armed;
         end
         if (taken || !req_valid) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() != 0 &&
                         !(req_backlog[0].wait_drain && (taken || sent_count != recv_count))) begin
               nxt = req_backlog.pop_front();
               req_data <= nxt.req;
               req_valid <= 1'b1;
               gap_left = nxt.gap;
               hold_armed = nxt.hold_rx;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rx_hold_kick <= kick;
      end
   end

   // monitor: takes results with random stalls and checks them in order
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            recv_count <= recv_count + 1;
            if (outcome_q.size() == 0)
               report_mismatch($sformatf("result %0d arrived with none expected", recv_count));
            else
               check_result(rsp_data, outcome_q.pop_front());
         end
         if (rx_hold_kick)
            hold_left = LONG_HOLD;
         if (phase_left == 0) begin
            calm_phase = ($urandom_range(0, 3) == 0);
            phase_left = $urandom_range(50, 200);
         end else begin
            phase_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 9) < 3) begin
            stall_left = idle_len();
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
